// ===== hw/rtl/srds_pkg.sv =====
// Package for the sphere ray diffuse shader: word types, register codes, constants.
`default_nettype none
package srds_pkg;

  localparam int IMG_SIZE = 2048;
  localparam int IMG_LOG2 = $clog2(IMG_SIZE);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 3'd7;

  localparam logic signed [15:0] RST_LIGHT_X    = 16'sd1024;
  localparam logic signed [15:0] RST_LIGHT_Y    = 16'sd1024;
  localparam logic signed [15:0] RST_LIGHT_Z    = -16'sd256;
  localparam logic signed [15:0] RST_CENTER_X   = 16'sd0;
  localparam logic signed [15:0] RST_CENTER_Y   = 16'sd3072;
  localparam logic signed [15:0] RST_CENTER_Z   = 16'sd0;
  localparam logic [14:0]        RST_RADIUS     = 15'd1536;
  localparam logic [14:0]        RST_HALF_WIDTH = 15'd2560;

  typedef struct packed {
    logic [10:0] pixel_col;
    logic [10:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [10:0]        out_col;
    logic [10:0]        out_row;
    logic               hit;
    logic signed [15:0] shade_dot;
    logic [7:0]         gray;
  } out_word_t;

  // carried alongside the first root extraction
  typedef struct packed {
    logic signed [16:0] wx;
    logic signed [16:0] wz;
    logic signed [17:0] dx;
    logic signed [17:0] dz;
    logic               hit;
    logic [10:0]        col;
    logic [10:0]        row;
  } sq1_side_t;

  // carried alongside the light distance root
  typedef struct packed {
    logic signed [37:0] num;
    logic               hit;
    logic [10:0]        col;
    logic [10:0]        row;
  } sq2_side_t;

  // carried alongside the divider
  typedef struct packed {
    logic        neg;
    logic        zero;
    logic        big;
    logic        hit;
    logic [10:0] col;
    logic [10:0] row;
  } div_side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/srds_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband word.
`default_nettype none
module srds_sqrt
  import srds_pkg::*;
#(
  parameter int IN_W   = 30,
  parameter int SIDE_W = 1,
  localparam int OUT_W = (IN_W + 1) / 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [IN_W-1:0]   in_val,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [OUT_W-1:0]       out_root,
  output logic [SIDE_W-1:0]      out_side
);

  logic              v    [1:OUT_W];
  logic [IN_W-1:0]   rem  [1:OUT_W];
  logic [OUT_W-1:0]  root [1:OUT_W];
  logic [SIDE_W-1:0] side [1:OUT_W];

  for (genvar j = 0; j < OUT_W; j++) begin : g_stage
    localparam int B = OUT_W - 1 - j;
    logic              vi;
    logic [IN_W-1:0]   ri;
    logic [OUT_W-1:0]  qi;
    logic [SIDE_W-1:0] si;
    logic [IN_W:0]     trial;
    logic              take;

    if (j == 0) begin : g_first
      assign vi = in_valid;
      assign ri = in_val;
      assign qi = '0;
      assign si = in_side;
    end else begin : g_next
      assign vi = v[j];
      assign ri = rem[j];
      assign qi = root[j];
      assign si = side[j];
    end

    // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B); low bits of q are still clear
    assign trial = ({{(IN_W + 1 - OUT_W){1'b0}}, qi} << (B + 1))
                 | ((IN_W + 1)'(1) << (2 * B));
    assign take  = {1'b0, ri} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= take ? IN_W'({1'b0, ri} - trial) : ri;
        root[j+1] <= take ? (qi | (OUT_W'(1) << B)) : qi;
        side[j+1] <= si;
      end
    end
  end

  assign out_valid = v[OUT_W];
  assign out_root  = root[OUT_W];
  assign out_side  = side[OUT_W];

endmodule
`default_nettype wire

// ===== hw/rtl/srds_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband word.
`default_nettype none
module srds_div
  import srds_pkg::*;
#(
  parameter int NUM_W  = 53,
  parameter int DEN_W  = 33,
  parameter int Q_W    = 17,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [Q_W-1:0]         out_quot,
  output logic [SIDE_W-1:0]      out_side
);

  logic              v    [1:Q_W];
  logic [NUM_W-1:0]  rem  [1:Q_W];
  logic [DEN_W-1:0]  den  [1:Q_W];
  logic [Q_W-1:0]    quot [1:Q_W];
  logic [SIDE_W-1:0] side [1:Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int B = Q_W - 1 - j;
    logic              vi;
    logic [NUM_W-1:0]  ri;
    logic [DEN_W-1:0]  di;
    logic [Q_W-1:0]    qi;
    logic [SIDE_W-1:0] si;
    logic [NUM_W-1:0]  sub;
    logic              take;

    if (j == 0) begin : g_first
      assign vi = in_valid;
      assign ri = in_num;
      assign di = in_den;
      assign qi = '0;
      assign si = in_side;
    end else begin : g_next
      assign vi = v[j];
      assign ri = rem[j];
      assign di = den[j];
      assign qi = quot[j];
      assign si = side[j];
    end

    assign sub  = {{(NUM_W - DEN_W){1'b0}}, di} << B;
    assign take = ri >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= take ? ri - sub : ri;
        den[j+1]  <= di;
        quot[j+1] <= take ? (qi | (Q_W'(1) << B)) : qi;
        side[j+1] <= si;
      end
    end
  end

  assign out_valid = v[Q_W];
  assign out_quot  = quot[Q_W];
  assign out_side  = side[Q_W];

endmodule
`default_nettype wire

// ===== hw/rtl/sphere_ray_diffuse_shader.sv =====
// Throughput: one word per cycle while the output skid register is empty; the two root
// pipelines (15 and 18 stages) and the 17-stage divider each take one bit per stage, so
// every stage holds its own word.
// A one-word skid register at the output keeps input open the cycle a result stalls.
// Reset (rst, synchronous) clears all valid bits and loads the default scene registers.
`default_nettype none
module sphere_ray_diffuse_shader
  import srds_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_data
);

  logic signed [15:0] light_x, light_y, light_z;
  logic signed [15:0] center_x, center_y, center_z;
  logic [14:0]        radius, half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x    <= RST_LIGHT_X;
      light_y    <= RST_LIGHT_Y;
      light_z    <= RST_LIGHT_Z;
      center_x   <= RST_CENTER_X;
      center_y   <= RST_CENTER_Y;
      center_z   <= RST_CENTER_Z;
      radius     <= RST_RADIUS;
      half_width <= RST_HALF_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIGHT_X:    light_x    <= cfg_data;
        CFG_LIGHT_Y:    light_y    <= cfg_data;
        CFG_LIGHT_Z:    light_z    <= cfg_data;
        CFG_CENTER_X:   center_x   <= cfg_data;
        CFG_CENTER_Y:   center_y   <= cfg_data;
        CFG_CENTER_Z:   center_z   <= cfg_data;
        CFG_RADIUS:     radius     <= cfg_data[14:0];
        CFG_HALF_WIDTH: half_width <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_full;
  out_word_t skid;

  assign en       = !skid_full;
  assign in_ready = !skid_full;

  // stage 1: index times half width
  logic v1;
  logic [10:0] col1, row1;
  logic [25:0] px1, pz1;

  // stage 2: world point and offset from centre
  logic v2;
  logic [10:0] col2, row2;
  logic signed [16:0] wx2, wz2;
  logic signed [17:0] dx2, dz2;
  logic [26:0] pxs, pzs;
  logic signed [16:0] wx_c, wz_c;

  // stage 3: squares
  logic v3;
  sq1_side_t s3;
  logic signed [35:0] dxx3, dzz3;
  logic [29:0] rr3;

  // stage 4: discriminant
  logic v4;
  sq1_side_t s4;
  logic [29:0] d4;
  logic signed [37:0] d_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign pxs  = {px1, 1'b0} >> IMG_LOG2;
  assign pzs  = {pz1, 1'b0} >> IMG_LOG2;
  assign wx_c = $signed({1'b0, pxs[15:0]}) - $signed({2'b00, half_width});
  assign wz_c = $signed({1'b0, pzs[15:0]}) - $signed({2'b00, half_width});
  assign d_c  = $signed({8'd0, rr3}) - {{2{dxx3[35]}}, dxx3} - {{2{dzz3[35]}}, dzz3};

  always_ff @(posedge clk) begin
    if (en) begin
      col1 <= in_data.pixel_col;
      row1 <= in_data.pixel_row;
      px1  <= in_data.pixel_col * half_width;
      pz1  <= in_data.pixel_row * half_width;

      col2 <= col1;
      row2 <= row1;
      wx2  <= wx_c;
      wz2  <= wz_c;
      dx2  <= {wx_c[16], wx_c} - {{2{center_x[15]}}, center_x};
      dz2  <= {wz_c[16], wz_c} - {{2{center_z[15]}}, center_z};

      s3.wx  <= wx2;
      s3.wz  <= wz2;
      s3.dx  <= dx2;
      s3.dz  <= dz2;
      s3.hit <= 1'b0;
      s3.col <= col2;
      s3.row <= row2;
      dxx3   <= dx2 * dx2;
      dzz3   <= dz2 * dz2;
      rr3    <= radius * radius;

      s4.wx  <= s3.wx;
      s4.wz  <= s3.wz;
      s4.dx  <= s3.dx;
      s4.dz  <= s3.dz;
      s4.hit <= !d_c[37];
      s4.col <= s3.col;
      s4.row <= s3.row;
      d4     <= d_c[37] ? '0 : d_c[29:0];
    end
  end

  logic v_sq1;
  logic [14:0] s_root;
  logic [$bits(sq1_side_t)-1:0] sq1_out;
  sq1_side_t q1;

  srds_sqrt #(.IN_W(30), .SIDE_W($bits(sq1_side_t))) u_sqrt_disc (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v4), .in_val(d4), .in_side(s4),
    .out_valid(v_sq1), .out_root(s_root), .out_side(sq1_out)
  );
  assign q1 = sq1_side_t'(sq1_out);

  // stage 5: light vector
  logic v5;
  logic [10:0] col5, row5;
  logic hit5;
  logic [14:0] sr5;
  logic signed [17:0] dx5, dz5, sx5, sy5, sz5;
  logic signed [16:0] iy_c;

  // stage 6: products
  logic v6;
  logic [10:0] col6, row6;
  logic hit6;
  logic signed [35:0] sxx6, syy6, szz6, p1_6, p3_6;
  logic signed [33:0] p2_6;

  // stage 7: sums
  logic v7;
  sq2_side_t s7;
  logic [35:0] ss7;

  assign iy_c = {center_y[15], center_y} - $signed({2'b00, s_root});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v5 <= v_sq1;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col5 <= q1.col;
      row5 <= q1.row;
      hit5 <= q1.hit;
      sr5  <= s_root;
      dx5  <= q1.dx;
      dz5  <= q1.dz;
      sx5  <= {{2{light_x[15]}}, light_x} - {q1.wx[16], q1.wx};
      sy5  <= {{2{light_y[15]}}, light_y} - {iy_c[16], iy_c};
      sz5  <= {{2{light_z[15]}}, light_z} - {q1.wz[16], q1.wz};

      col6 <= col5;
      row6 <= row5;
      hit6 <= hit5;
      sxx6 <= sx5 * sx5;
      syy6 <= sy5 * sy5;
      szz6 <= sz5 * sz5;
      p1_6 <= dx5 * sx5;
      p2_6 <= $signed({1'b0, sr5}) * sy5;
      p3_6 <= dz5 * sz5;

      ss7     <= sxx6[35:0] + syy6[35:0] + szz6[35:0];
      s7.num  <= {{2{p1_6[35]}}, p1_6} - {{4{p2_6[33]}}, p2_6} + {{2{p3_6[35]}}, p3_6};
      s7.hit  <= hit6;
      s7.col  <= col6;
      s7.row  <= row6;
    end
  end

  logic v_sq2;
  logic [17:0] slen;
  logic [$bits(sq2_side_t)-1:0] sq2_out;
  sq2_side_t q2;

  srds_sqrt #(.IN_W(36), .SIDE_W($bits(sq2_side_t))) u_sqrt_light (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v7), .in_val(ss7), .in_side(s7),
    .out_valid(v_sq2), .out_root(slen), .out_side(sq2_out)
  );
  assign q2 = sq2_side_t'(sq2_out);

  // stage 8: divisor and magnitude
  logic v8;
  div_side_t s8;
  logic [32:0] den8;
  logic [37:0] mag8;

  // stage 9: saturation check, dividend
  logic v9;
  div_side_t s9;
  logic [32:0] den9;
  logic [52:0] num9;
  logic big_c, zero_c;

  assign zero_c = den8 == '0;
  assign big_c  = mag8 >= {3'b000, den8, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v8 <= v_sq2;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den8    <= radius * slen;
      mag8    <= q2.num[37] ? 38'(-q2.num) : q2.num;
      s8.neg  <= q2.num[37];
      s8.zero <= 1'b0;
      s8.big  <= 1'b0;
      s8.hit  <= q2.hit;
      s8.col  <= q2.col;
      s8.row  <= q2.row;

      s9.neg  <= s8.neg;
      s9.zero <= zero_c;
      s9.big  <= big_c;
      s9.hit  <= s8.hit;
      s9.col  <= s8.col;
      s9.row  <= s8.row;
      den9    <= den8;
      // a quotient of 2^17 or more saturates anyway, so only smaller ones are divided
      num9    <= (zero_c || big_c) ? '0 : {mag8, 15'd0};
    end
  end

  logic v_div;
  logic [16:0] quot;
  logic [$bits(div_side_t)-1:0] div_out;
  div_side_t qd;

  srds_div #(.NUM_W(53), .DEN_W(33), .Q_W(17), .SIDE_W($bits(div_side_t))) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v9), .in_num(num9), .in_den(den9), .in_side(s9),
    .out_valid(v_div), .out_quot(quot), .out_side(div_out)
  );
  assign qd = div_side_t'(div_out);

  // stage 10: clamp, gray level
  logic v10;
  out_word_t w10;
  logic signed [15:0] dot_c;
  logic [22:0] g_prod;

  always_comb begin
    if (!qd.hit || qd.zero) begin
      dot_c = '0;
    end else if (qd.neg) begin
      dot_c = (qd.big || quot > 17'd32768) ? 16'sh8000 : 16'(17'd0 - quot);
    end else begin
      dot_c = (qd.big || quot > 17'd32767) ? 16'sh7fff : quot[15:0];
    end
  end

  assign g_prod = {dot_c[14:0], 8'd0} - {8'd0, dot_c[14:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v_div;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w10.out_col   <= qd.col;
      w10.out_row   <= qd.row;
      w10.hit       <= qd.hit;
      w10.shade_dot <= dot_c;
      w10.gray      <= (dot_c > 16'sd0) ? g_prod[22:15] : 8'd0;
    end
  end

  // skid: catches the last stage's word when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) skid_full <= 1'b0;
    end else if (v10 && !out_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) skid <= w10;
  end

  assign out_valid = skid_full || v10;
  assign out_data  = skid_full ? skid : w10;

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_full && !out_ready |=> skid_full && $stable(skid))
    else $error("skid word lost while stalled");

  a_miss_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.shade_dot == 16'sd0 && out_data.gray == 8'd0)
    else $error("miss with nonzero shade");

  a_gray_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.gray != 8'd0 |-> out_data.shade_dot > 16'sd0)
    else $error("gray set on unlit word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("valid word right after reset");

endmodule
`default_nettype wire

// ===== tb/sphere_ray_diffuse_shader_test.sv =====
// Self-checking testbench for the sphere ray diffuse shader: directed table, then random pixels.
`default_nettype none
module sphere_ray_diffuse_shader_test
  import srds_pkg::*;
;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;

  sphere_ray_diffuse_shader i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // scene registers as the shader should hold them
  longint lx, ly, lz, cx, cy, cz, rad, hw;

  out_word_t shade_q[$];
  int        n_bad;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint root_floor(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint to_world(logic [10:0] idx);
    return (longint'(idx) * 2 * hw) / IMG_SIZE - hw;
  endfunction

  function automatic out_word_t shade_pixel(in_word_t px);
    out_word_t o;
    longint wx, wz, dx, dz, disc, s, sx, sy, sz, slen, num, den, mag, q, dot;
    wx = to_world(px.pixel_col);
    wz = to_world(px.pixel_row);
    dx = wx - cx;
    dz = wz - cz;
    disc = rad * rad - dx * dx - dz * dz;
    dot = 0;
    o = '0;
    o.out_col = px.pixel_col;
    o.out_row = px.pixel_row;
    if (disc >= 0) begin
      s = root_floor(disc);
      sx = lx - wx;
      sy = ly - (cy - s);
      sz = lz - wz;
      slen = root_floor(sx * sx + sy * sy + sz * sz);
      num = dx * sx - s * sy + dz * sz;
      den = rad * slen;
      o.hit = 1'b1;
      if (den != 0) begin
        mag = (num < 0) ? -num : num;
        q = (mag <<< 15) / den;
        if (num < 0) dot = (q > 32768) ? -32768 : -q;
        else dot = (q > 32767) ? 32767 : q;
      end
      if (dot > 0) o.gray = 8'((dot * 255) >>> 15);
    end
    o.shade_dot = 16'(dot);
    return o;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LIGHT_X:    lx  = longint'($signed(val));
      CFG_LIGHT_Y:    ly  = longint'($signed(val));
      CFG_LIGHT_Z:    lz  = longint'($signed(val));
      CFG_CENTER_X:   cx  = longint'($signed(val));
      CFG_CENTER_Y:   cy  = longint'($signed(val));
      CFG_CENTER_Z:   cz  = longint'($signed(val));
      CFG_RADIUS:     rad = longint'(val[14:0]);
      CFG_HALF_WIDTH: hw  = longint'(val[14:0]);
      default: ;
    endcase
  endtask

  // called on a falling edge; leaves valid high after the accept so words can follow
  task automatic send_pixel(in_word_t px);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shade_q.push_back(shade_pixel(px));
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (shade_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  // receiver: random stalls, plus an occasional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (shade_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word %p", out_data);
      end else begin
        exp_w = shade_q.pop_front();
        if (out_data.out_col !== exp_w.out_col || out_data.out_row !== exp_w.out_row ||
            out_data.hit !== exp_w.hit || out_data.shade_dot !== exp_w.shade_dot ||
            out_data.gray !== exp_w.gray) begin
          n_bad++;
          if (n_bad <= 10) $display("mismatch: expected %p, got %p", exp_w, out_data);
        end
      end
    end
  end

  typedef struct {
    logic [10:0] col;
    logic [10:0] row;
    logic        known;
    logic        hit;
    logic [15:0] dot;
    logic [7:0]  gray;
  } pixel_row_t;

  // reset scene: sphere centred in front of the window
  pixel_row_t dir_tab[] = '{
    '{11'd0,    11'd0,    1'b1, 1'b0, 16'd0, 8'd0},  // corner, miss
    '{11'd2047, 11'd2047, 1'b1, 1'b0, 16'd0, 8'd0},
    '{11'd0,    11'd2047, 1'b1, 1'b0, 16'd0, 8'd0},
    '{11'd2047, 11'd0,    1'b1, 1'b0, 16'd0, 8'd0},
    '{11'd1024, 11'd1024, 1'b0, 1'b0, 16'd0, 8'd0},  // centre hit
    '{11'd1100, 11'd900,  1'b0, 1'b0, 16'd0, 8'd0},
    '{11'd700,  11'd1024, 1'b0, 1'b0, 16'd0, 8'd0},
    '{11'd1024, 11'd1638, 1'b0, 1'b0, 16'd0, 8'd0},  // rim
    '{11'd1638, 11'd1024, 1'b0, 1'b0, 16'd0, 8'd0},
    '{11'd1700, 11'd1024, 1'b1, 1'b0, 16'd0, 8'd0},  // just outside
    '{11'd1000, 11'd1300, 1'b0, 1'b0, 16'd0, 8'd0},  // off-centre hit, lit side
    '{11'd1555, 11'd682,  1'b0, 1'b0, 16'd0, 8'd0}
  };

  task automatic random_scene(bit wide);
    write_reg(CFG_LIGHT_X, wide ? 16'($urandom) : 16'($urandom_range(4096) - 2048));
    write_reg(CFG_LIGHT_Y, wide ? 16'($urandom) : 16'($urandom_range(4096) - 2048));
    write_reg(CFG_LIGHT_Z, wide ? 16'($urandom) : 16'($urandom_range(4096) - 2048));
    write_reg(CFG_CENTER_X, 16'($urandom_range(2048) - 1024));
    write_reg(CFG_CENTER_Y, wide ? 16'($urandom) : 16'($urandom_range(6000)));
    write_reg(CFG_CENTER_Z, 16'($urandom_range(2048) - 1024));
    write_reg(CFG_RADIUS, 16'($urandom_range(3000, 1)));
    write_reg(CFG_HALF_WIDTH, 16'($urandom_range(3000, 1)));
  endtask

  task automatic random_pixels(int n);
    in_word_t px;
    for (int k = 0; k < n; k++) begin
      px.pixel_col = 11'($urandom);
      px.pixel_row = 11'($urandom);
      send_pixel(px);
    end
  endtask

  initial begin
    in_word_t px;
    out_word_t w;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_data = '0;
    n_bad = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    lx = RST_LIGHT_X; ly = RST_LIGHT_Y; lz = RST_LIGHT_Z;
    cx = RST_CENTER_X; cy = RST_CENTER_Y; cz = RST_CENTER_Z;
    rad = RST_RADIUS; hw = RST_HALF_WIDTH;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[k]) begin
      px.pixel_col = dir_tab[k].col;
      px.pixel_row = dir_tab[k].row;
      send_pixel(px);
      if (dir_tab[k].known) begin
        // table value replaces the predicted one for these rows
        w = shade_q.pop_back();
        w.hit = dir_tab[k].hit;
        w.shade_dot = dir_tab[k].dot;
        w.gray = dir_tab[k].gray;
        shade_q.push_back(w);
      end
    end
    drain();

    // light at the hit point: zero divisor; then extreme registers
    write_reg(CFG_LIGHT_X, 16'd0);
    write_reg(CFG_LIGHT_Y, 16'd1536);
    write_reg(CFG_LIGHT_Z, 16'd0);
    px.pixel_col = 11'd1024; px.pixel_row = 11'd1024;
    send_pixel(px);
    drain();
    write_reg(CFG_LIGHT_X, 16'h8000);
    write_reg(CFG_LIGHT_Y, 16'h7fff);
    write_reg(CFG_LIGHT_Z, 16'h8000);
    write_reg(CFG_RADIUS, 16'h7fff);
    write_reg(CFG_HALF_WIDTH, 16'h7fff);
    write_reg(CFG_CENTER_X, 16'h7fff);
    write_reg(CFG_CENTER_Y, 16'h8000);
    write_reg(CFG_CENTER_Z, 16'h8000);
    random_pixels(8);
    drain();
    write_reg(CFG_RADIUS, 16'd1);
    write_reg(CFG_HALF_WIDTH, 16'd1);
    write_reg(CFG_CENTER_X, 16'd0);
    write_reg(CFG_CENTER_Z, 16'd0);
    random_pixels(8);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      random_scene(ph == 7);
      if (ph == 4) hold_cycles = 300;  // fill the pipeline and back up the input
      random_pixels(180);
      drain();
    end

    if (n_bad == 0 && shade_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
